// ===== sv/bmhq_pkg.sv =====
// Shared types and constants for the binary min-heap queue.
// Used by every module of the block but the RAM; depends on nothing else.

package bmhq_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int ID_W          = 8;
    localparam int PRIO_W        = 48;
    localparam int ENTRY_W       = ID_W + PRIO_W;
    localparam int CAP_W         = 7;
    localparam int FILL_W        = 7;
    localparam int S_TDATA_W     = 56;
    localparam int M_TDATA_W     = 64;
    localparam int M_TUSER_W     = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [0:0] {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH_RD,
        ST_PUSH_CMP,
        ST_POP_ROOT,
        ST_POP_LAST,
        ST_DN_RDL,
        ST_DN_RDR,
        ST_DN_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        status_t           status;
        logic              popped_valid;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [FILL_W-1:0] fill;
    } result_t;

endpackage

// ===== sv/bmhq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.

module bmhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/bmhq_out.sv =====
// Output register stage: holds one finished result until the sink takes it.
// Depends on bmhq_pkg for the result structure and field widths.

module bmhq_out (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                load,
    input  bmhq_pkg::result_t                   result,
    output logic                                can_load,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bmhq_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [bmhq_pkg::M_TUSER_W-1:0]      m_tuser
);

    logic              valid_reg;
    bmhq_pkg::result_t data_reg;

    assign can_load = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (can_load && load) begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, data_reg.fill, data_reg.prio, data_reg.id};
    assign m_tuser  = {data_reg.popped_valid, data_reg.status};

endmodule

// ===== sv/bmhq_seq.sv =====
// Heap sequencer: walks the heap one level at a time through the entry RAM,
// with a single shared priority comparator. Depends on bmhq_pkg and bmhq_ram.

module bmhq_seq #(
    parameter int DEPTH = bmhq_pkg::DEPTH_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [bmhq_pkg::CAP_W-1:0]      cap_limit,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  bmhq_pkg::opcode_t               in_op,
    input  logic [bmhq_pkg::ID_W-1:0]       in_id,
    input  logic [bmhq_pkg::PRIO_W-1:0]     in_prio,
    output logic                            res_load,
    output bmhq_pkg::result_t               res,
    input  logic                            res_can_load
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int LW  = (CW > bmhq_pkg::CAP_W) ? CW : bmhq_pkg::CAP_W;
    localparam int XW  = AW + 2;
    localparam int IW  = bmhq_pkg::ID_W;
    localparam int PW  = bmhq_pkg::PRIO_W;
    localparam int EW  = bmhq_pkg::ENTRY_W;

    bmhq_pkg::state_t  state_reg, state_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [IW-1:0]     x_id_reg, x_id_next;
    logic [PW-1:0]     x_prio_reg, x_prio_next;
    logic [IW-1:0]     cand_id_reg, cand_id_next;
    logic [PW-1:0]     cand_prio_reg, cand_prio_next;
    logic              left_better_reg, left_better_next;
    bmhq_pkg::status_t res_status_reg, res_status_next;
    logic              res_valid_reg, res_valid_next;
    logic [IW-1:0]     res_id_reg, res_id_next;
    logic [PW-1:0]     res_prio_reg, res_prio_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] rd_data;
    logic [IW-1:0] rd_id;
    logic [PW-1:0] rd_prio;

    logic [PW-1:0] cmp_a;
    logic [PW-1:0] cmp_b;
    logic          cmp_lt;

    logic [AW-1:0] parent;
    logic [XW-1:0] left_idx;
    logic [XW-1:0] right_idx;
    logic [XW-1:0] count_x;
    logic          heap_full;

    bmhq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_id   = rd_data[IW-1:0];
    assign rd_prio = rd_data[EW-1:IW];

    // The one comparator of the block; operands are steered by the state.
    assign cmp_lt = cmp_a < cmp_b;

    assign parent    = (pos_reg - AW'(1)) >> 1;
    assign left_idx  = {1'b0, pos_reg, 1'b1};
    assign right_idx = {1'b0, pos_reg, 1'b0} + XW'(2);
    assign count_x   = XW'(count_reg);
    assign heap_full = (LW'(count_reg) >= LW'(cap_limit)) || (count_reg >= CW'(DEPTH));

    assign in_ready = (state_reg == bmhq_pkg::ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bmhq_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg         <= pos_next;
        x_id_reg        <= x_id_next;
        x_prio_reg      <= x_prio_next;
        cand_id_reg     <= cand_id_next;
        cand_prio_reg   <= cand_prio_next;
        left_better_reg <= left_better_next;
        res_status_reg  <= res_status_next;
        res_valid_reg   <= res_valid_next;
        res_id_reg      <= res_id_next;
        res_prio_reg    <= res_prio_next;
    end

    always_comb begin
        state_next       = state_reg;
        pos_next         = pos_reg;
        count_next       = count_reg;
        x_id_next        = x_id_reg;
        x_prio_next      = x_prio_reg;
        cand_id_next     = cand_id_reg;
        cand_prio_next   = cand_prio_reg;
        left_better_next = left_better_reg;
        res_status_next  = res_status_reg;
        res_valid_next   = res_valid_reg;
        res_id_next      = res_id_reg;
        res_prio_next    = res_prio_reg;
        wr_en            = 1'b0;
        wr_addr          = pos_reg;
        wr_data          = {x_prio_reg, x_id_reg};
        rd_addr          = '0;
        cmp_a            = x_prio_reg;
        cmp_b            = rd_prio;
        res_load         = 1'b0;

        unique case (state_reg)
            bmhq_pkg::ST_IDLE: begin
                // The read port sits on the root so a pop finds it next cycle.
                rd_addr = '0;
                if (in_valid) begin
                    res_status_next = bmhq_pkg::STATUS_DONE;
                    res_valid_next  = 1'b0;
                    res_id_next     = '0;
                    res_prio_next   = '0;
                    if (in_op == bmhq_pkg::OP_PUSH) begin
                        if (heap_full) begin
                            res_status_next = bmhq_pkg::STATUS_FULL;
                            state_next      = bmhq_pkg::ST_DONE;
                        end else begin
                            x_id_next   = in_id;
                            x_prio_next = in_prio;
                            pos_next    = AW'(count_reg);
                            state_next  = bmhq_pkg::ST_PUSH_RD;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            res_status_next = bmhq_pkg::STATUS_EMPTY;
                            state_next      = bmhq_pkg::ST_DONE;
                        end else begin
                            res_valid_next = 1'b1;
                            state_next     = bmhq_pkg::ST_POP_ROOT;
                        end
                    end
                end
            end

            bmhq_pkg::ST_PUSH_RD: begin
                if (pos_reg == '0) begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CW'(1);
                    state_next = bmhq_pkg::ST_DONE;
                end else begin
                    rd_addr    = parent;
                    state_next = bmhq_pkg::ST_PUSH_CMP;
                end
            end

            bmhq_pkg::ST_PUSH_CMP: begin
                // Parent moves down into the hole while it is strictly greater.
                cmp_a = x_prio_reg;
                cmp_b = rd_prio;
                wr_en = 1'b1;
                if (cmp_lt) begin
                    wr_data    = rd_data;
                    pos_next   = parent;
                    state_next = bmhq_pkg::ST_PUSH_RD;
                end else begin
                    count_next = count_reg + CW'(1);
                    state_next = bmhq_pkg::ST_DONE;
                end
            end

            bmhq_pkg::ST_POP_ROOT: begin
                res_id_next   = rd_id;
                res_prio_next = rd_prio;
                rd_addr       = AW'(count_reg - CW'(1));
                state_next    = bmhq_pkg::ST_POP_LAST;
            end

            bmhq_pkg::ST_POP_LAST: begin
                x_id_next   = rd_id;
                x_prio_next = rd_prio;
                count_next  = count_reg - CW'(1);
                pos_next    = '0;
                state_next  = bmhq_pkg::ST_DN_RDL;
            end

            bmhq_pkg::ST_DN_RDL: begin
                if (left_idx >= count_x) begin
                    wr_en      = 1'b1;
                    state_next = bmhq_pkg::ST_DONE;
                end else begin
                    rd_addr    = AW'(left_idx);
                    state_next = bmhq_pkg::ST_DN_RDR;
                end
            end

            bmhq_pkg::ST_DN_RDR: begin
                cmp_a            = rd_prio;
                cmp_b            = x_prio_reg;
                left_better_next = cmp_lt;
                cand_id_next     = rd_id;
                cand_prio_next   = rd_prio;
                // The right child may lie past the end; its data is then ignored.
                rd_addr          = AW'(right_idx);
                state_next       = bmhq_pkg::ST_DN_CMP;
            end

            bmhq_pkg::ST_DN_CMP: begin
                cmp_a = rd_prio;
                cmp_b = left_better_reg ? cand_prio_reg : x_prio_reg;
                wr_en = 1'b1;
                if ((right_idx < count_x) && cmp_lt) begin
                    wr_data    = rd_data;
                    pos_next   = AW'(right_idx);
                    state_next = bmhq_pkg::ST_DN_RDL;
                end else if (left_better_reg) begin
                    wr_data    = {cand_prio_reg, cand_id_reg};
                    pos_next   = AW'(left_idx);
                    state_next = bmhq_pkg::ST_DN_RDL;
                end else begin
                    state_next = bmhq_pkg::ST_DONE;
                end
            end

            bmhq_pkg::ST_DONE: begin
                if (res_can_load) begin
                    res_load   = 1'b1;
                    state_next = bmhq_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = bmhq_pkg::ST_IDLE;
            end
        endcase
    end

    assign res.status       = res_status_reg;
    assign res.popped_valid = res_valid_reg;
    assign res.id           = res_id_reg;
    assign res.prio         = res_prio_reg;
    assign res.fill         = bmhq_pkg::FILL_W'(count_reg);

endmodule

// ===== sv/binary_min_heap_queue.sv =====
// Top level of the binary min-heap queue: configuration register, heap
// sequencer and output stage. Depends on bmhq_pkg, bmhq_seq and bmhq_out.

// A binary min-heap of (id, priority) entries kept in a single-port-read RAM
// and served smallest priority first; one result beat comes back for every
// input beat. One item is worked on at a time and s_tready is low meanwhile.
// Every heap level costs RAM reads through the one read port, and s_tready
// rises in the cycle after the result is loaded. A push while the heap holds
// at least min(capacity_limit, DEPTH) entries is dropped with a full status;
// a pop on an empty heap reports empty and leaves the heap alone.
// The result register lets the next item start while a result waits.

module binary_min_heap_queue #(
    parameter int DEPTH = bmhq_pkg::DEPTH_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration: capacity_limit.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bmhq_pkg::CAP_W-1:0]         cfg_data,
    // s_tdata: entry_id [7:0], entry_priority [55:8].
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bmhq_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: opcode [0].
    input  logic [0:0]                         s_tuser,
    // m_tdata: popped_id [7:0], popped_priority [55:8], fill_count [62:56].
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bmhq_pkg::M_TDATA_W-1:0]     m_tdata,
    // m_tuser: status [1:0], popped_valid [2].
    output logic [bmhq_pkg::M_TUSER_W-1:0]     m_tuser
);

    localparam int IW = bmhq_pkg::ID_W;
    localparam int PW = bmhq_pkg::PRIO_W;

    logic [bmhq_pkg::CAP_W-1:0] cap_reg;
    logic                       res_load;
    logic                       res_can_load;
    bmhq_pkg::result_t          res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= bmhq_pkg::CAP_RESET;
        end else if (cfg_valid) begin
            cap_reg <= cfg_data;
        end
    end

    bmhq_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cap_limit    (cap_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_op        (bmhq_pkg::opcode_t'(s_tuser[0])),
        .in_id        (s_tdata[IW-1:0]),
        .in_prio      (s_tdata[IW+PW-1:IW]),
        .res_load     (res_load),
        .res          (res),
        .res_can_load (res_can_load)
    );

    bmhq_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (res_load),
        .result   (res),
        .can_load (res_can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTH
    // An accepted item keeps the block busy for at least the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // A successful push always leaves at least one entry behind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1:0] == bmhq_pkg::STATUS_DONE) && !m_tuser[2]
        |-> m_tdata[62:56] != '0)
        else $error("successful push reported an empty heap");

    // An empty report carries no entry and a zero fill.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1:0] == bmhq_pkg::STATUS_EMPTY)
        |-> !m_tuser[2] && (m_tdata[62:56] == '0))
        else $error("empty status with entries held");
`endif

endmodule

// ===== test/binary_min_heap_queue_test.sv =====
// Self-checking testbench for binary_min_heap_queue: directed and random push/pop
// traffic, capacity register writes and random stalls on both streams.
// Depends on bmhq_pkg and the binary_min_heap_queue RTL only.

module binary_min_heap_queue_test;
    import bmhq_pkg::*;

    localparam int HEAP_DEPTH  = 64;
    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_REPORTS = 10;
    localparam logic [PRIO_W-1:0] PRIO_MAX = {PRIO_W{1'b1}};

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CAP_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [0:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // Predicted heap contents and register.
    logic [ID_W-1:0]   heap_tag [HEAP_DEPTH];
    logic [PRIO_W-1:0] heap_key [HEAP_DEPTH];
    int                heap_size = 0;
    int                cap_limit = int'(CAP_RESET);

    result_t pending_results[$];
    int      mismatch_count = 0;
    int      send_idle_pct  = 0;
    int      recv_idle_pct  = 0;
    int      cycle_count    = 0;

    binary_min_heap_queue #(.DEPTH(HEAP_DEPTH)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // entry_id [7:0], entry_priority [55:8]
        .s_tuser   (s_tuser),   // opcode [0]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // popped_id [7:0], popped_priority [55:8], fill_count [62:56]
        .m_tuser   (m_tuser)    // status [1:0], popped_valid [2]
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL binary_min_heap_queue");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void swap_entries(int a, int b);
        logic [ID_W-1:0]   t;
        logic [PRIO_W-1:0] k;
        t = heap_tag[a];
        k = heap_key[a];
        heap_tag[a] = heap_tag[b];
        heap_key[a] = heap_key[b];
        heap_tag[b] = t;
        heap_key[b] = k;
    endfunction

    // Applies one push or pop to the predicted heap and returns the result it gives.
    function automatic result_t apply_heap_op(opcode_t op, logic [ID_W-1:0] id,
                                              logic [PRIO_W-1:0] prio);
        result_t r;
        int      lim;
        int      pos;
        int      best;
        bit      settled;
        r = '0;
        r.status = STATUS_DONE;
        lim = (cap_limit > HEAP_DEPTH) ? HEAP_DEPTH : cap_limit;
        if (op == OP_PUSH) begin
            if (heap_size >= lim) begin
                r.status = STATUS_FULL;
            end else begin
                pos = heap_size;
                heap_tag[pos] = id;
                heap_key[pos] = prio;
                while (pos > 0 && heap_key[(pos - 1) / 2] > heap_key[pos]) begin
                    swap_entries((pos - 1) / 2, pos);
                    pos = (pos - 1) / 2;
                end
                heap_size++;
            end
        end else if (heap_size == 0) begin
            r.status = STATUS_EMPTY;
        end else begin
            r.popped_valid = 1'b1;
            r.id = heap_tag[0];
            r.prio = heap_key[0];
            heap_size--;
            heap_tag[0] = heap_tag[heap_size];
            heap_key[0] = heap_key[heap_size];
            pos = 0;
            settled = 1'b0;
            // The left child wins only if strictly smaller, then the right likewise.
            while (!settled) begin
                best = pos;
                if (2 * pos + 1 < heap_size && heap_key[2 * pos + 1] < heap_key[best])
                    best = 2 * pos + 1;
                if (2 * pos + 2 < heap_size && heap_key[2 * pos + 2] < heap_key[best])
                    best = 2 * pos + 2;
                if (best == pos) begin
                    settled = 1'b1;
                end else begin
                    swap_entries(pos, best);
                    pos = best;
                end
            end
        end
        r.fill = heap_size[FILL_W-1:0];
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] expected,
                                        logic [63:0] actual);
        if (expected !== actual) begin
            if (mismatch_count < MAX_REPORTS)
                $display("mismatch in %s: expected %0h, got %0h", name, expected, actual);
            mismatch_count++;
        end
    endfunction

    // Result monitor: every result beat is matched against the oldest prediction.
    always @(posedge aclk) begin
        result_t r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("result beat with no prediction waiting: tdata %0h tuser %0h",
                             m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                r = pending_results.pop_front();
                check_field("status", 64'(r.status), 64'(m_tuser[1:0]));
                check_field("popped_valid", 64'(r.popped_valid), 64'(m_tuser[2]));
                check_field("popped_id", 64'(r.id), 64'(m_tdata[7:0]));
                check_field("popped_priority", 64'(r.prio), 64'(m_tdata[55:8]));
                check_field("fill_count", 64'(r.fill), 64'(m_tdata[62:56]));
            end
        end
    end

    // Sends one beat; s_tvalid stays high afterwards so back-to-back beats need no gap.
    task automatic send_item(opcode_t op, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {prio, id};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(apply_heap_op(op, id, prio));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic set_capacity(int value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= CAP_W'(value);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cap_limit = value;
    endtask

    task automatic test_extremes();
        send_item(OP_POP, 8'h00, '0);
        send_item(OP_PUSH, 8'hFF, PRIO_MAX);
        send_item(OP_PUSH, 8'h00, '0);
        send_item(OP_PUSH, 8'h5A, 48'hA5A5_5A5A_A5A5);
        repeat (3) send_item(OP_POP, 8'hFF, PRIO_MAX);
        send_item(OP_POP, 8'h00, '0);
    endtask

    // Equal keys: the order that comes out follows the swap rules alone.
    task automatic test_equal_priorities();
        for (int i = 1; i <= 4; i++) send_item(OP_PUSH, 8'(i), 48'd5);
        repeat (4) send_item(OP_POP, 8'h00, '0);
    endtask

    task automatic test_capacity_limits();
        set_capacity(1);
        send_item(OP_PUSH, 8'h11, 48'd100);
        send_item(OP_PUSH, 8'h12, 48'd1);
        send_item(OP_POP, 8'h00, '0);
        set_capacity(0);
        send_item(OP_PUSH, 8'h13, 48'd7);
        set_capacity(64);
        for (int i = 0; i < 3; i++) send_item(OP_PUSH, 8'(8'h20 + i), 48'(30 - i));
        // Lowering the limit below the fill keeps the held entries but drops pushes.
        set_capacity(2);
        send_item(OP_PUSH, 8'h30, 48'd0);
        repeat (3) send_item(OP_POP, 8'h00, '0);
    endtask

    task automatic test_random_traffic(int cap, int count, int push_pct);
        logic [PRIO_W-1:0] prio;
        int                pick;
        set_capacity(cap);
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 40)
                prio = 48'($urandom_range(7));
            else if (pick < 50)
                prio = ($urandom_range(1) != 0) ? PRIO_MAX : '0;
            else
                prio = {16'($urandom), 32'($urandom)};
            send_item(($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP,
                      8'($urandom_range(255)), prio);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 30;
        recv_idle_pct = 45;
        test_extremes();
        test_equal_priorities();
        test_capacity_limits();
        test_random_traffic(127, 300, 65);
        test_random_traffic(64, 300, 50);

        send_idle_pct = 45;
        recv_idle_pct = 30;
        test_random_traffic(1, 100, 50);
        test_random_traffic(9, 250, 55);
        test_random_traffic(0, 50, 50);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(33, 300, 45);
        test_random_traffic(64, 350, 60);

        wait_idle();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0)
            $display("PASS binary_min_heap_queue");
        else
            $display("FAIL binary_min_heap_queue");
        $finish;
    end

endmodule
